### rtl/masked_dual_screen_pixel_ram_macros.svh
// assertion macros shared by the masked dual screen pixel ram rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef MASKED_DUAL_SCREEN_PIXEL_RAM_MACROS_SVH
`define MASKED_DUAL_SCREEN_PIXEL_RAM_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MDSPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define MDSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mdspr_pkg.sv
// shared types, constants and pixel decode for the masked dual screen pixel ram
// no dependencies
`timescale 1ns / 1ps

package mdspr_pkg;

  // memory geometry, word counts must be powers of two
  localparam int MEM_WORDS    = 262144;
  localparam int ROW_WORDS    = 512;
  localparam int SCREEN_WORDS = 131072;
  localparam int ADDR_W       = $clog2(MEM_WORDS);

  // width that holds screen base + y * row + x before wrapping
  localparam int PIX_SUM_W = $clog2(SCREEN_WORDS + 256 * ROW_WORDS + 512);

  localparam logic [15:0] CTRL_READ_VALUE = 16'h0060;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_RAM_RD   = 3'd0,
    OP_RAM_WR   = 3'd1,
    OP_CTRL_WR  = 3'd2,
    OP_CTRL_RD  = 3'd3,
    OP_MASK_WR  = 3'd4,
    OP_PIX_FETCH = 3'd5
  } opcode_e;

  // what the back end has to do with a queued word
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_RAM_RD,
    KIND_RAM_WR,
    KIND_CTRL_RD,
    KIND_PIX
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
    logic [15:0]       bit_en;
  } op_t;

  // video word to 12-bit palette index
  function automatic logic [11:0] decode_pixel(logic [15:0] w);
    logic [11:0] c;
    c = {1'b0, w[8:6], 8'h00};
    if (w[15]) begin
      c[11] = 1'b1;
      // bit 13 set blanks the low nibble
      c[3:0] = w[13] ? 4'h0 : w[12:9];
    end else begin
      c[3:0] = w[3:0];
    end
    return c;
  endfunction

endpackage

### rtl/mdspr_front.sv
// front end: accepts words, keeps ctrl and mask registers, builds queue entries
// depends on mdspr_pkg
`timescale 1ns / 1ps

module mdspr_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               opcode_i,
  input  logic [17:0]              word_address_i,
  input  logic [15:0]              write_data_i,
  input  logic [1:0]               byte_lanes_i,
  input  logic [8:0]               pixel_x_i,
  input  logic [7:0]               pixel_y_i,
  input  logic                     full_i,
  output logic                     push_o,
  output mdspr_pkg::op_t           push_op_o
);
  import mdspr_pkg::*;

  logic [15:0]          ctrl_q, ctrl_d;
  logic [15:0]          mask_q, mask_d;
  logic [15:0]          lane_en;
  logic [PIX_SUM_W-1:0] pix_sum;
  logic                 accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign lane_en    = {{8{byte_lanes_i[1]}}, {8{byte_lanes_i[0]}}};

  // pixel address, wraps on the memory size
  assign pix_sum = (ctrl_q[0] ? PIX_SUM_W'(SCREEN_WORDS) : '0)
                 + PIX_SUM_W'(pixel_y_i) * PIX_SUM_W'(ROW_WORDS)
                 + PIX_SUM_W'(pixel_x_i);

  // classify the word and update registers
  always_comb begin
    ctrl_d           = ctrl_q;
    mask_d           = mask_q;
    push_op_o.kind   = KIND_NONE;
    push_op_o.addr   = word_address_i[ADDR_W-1:0];
    push_op_o.data   = write_data_i;
    push_op_o.bit_en = lane_en & mask_q;
    unique case (opcode_e'(opcode_i))
      OP_RAM_RD:    push_op_o.kind = KIND_RAM_RD;
      OP_RAM_WR:    push_op_o.kind = KIND_RAM_WR;
      OP_CTRL_WR:   ctrl_d = (ctrl_q & ~lane_en) | (write_data_i & lane_en);
      OP_CTRL_RD:   push_op_o.kind = KIND_CTRL_RD;
      OP_MASK_WR:   mask_d = (mask_q & ~lane_en) | (write_data_i & lane_en);
      OP_PIX_FETCH: begin
        push_op_o.kind = KIND_PIX;
        push_op_o.addr = pix_sum[ADDR_W-1:0];
      end
      default:      push_op_o.kind = KIND_NONE;
    endcase
  end

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      mask_q <= '0;
    end else if (accept) begin
      ctrl_q <= ctrl_d;
      mask_q <= mask_d;
    end
  end

endmodule

### rtl/mdspr_queue.sv
// short queue of operations between front and back end
// depends on mdspr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "masked_dual_screen_pixel_ram_macros.svh"

module mdspr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mdspr_pkg::op_t push_op_i,
  input  logic           pop_i,
  output mdspr_pkg::op_t pop_op_o,
  output logic           full_o,
  output logic           empty_o
);
  import mdspr_pkg::*;

  op_t             slot_q [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] count_q;

  assign full_o   = (count_q == Q_CW'(Q_DEPTH));
  assign empty_o  = (count_q == '0);
  assign pop_op_o = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `MDSPR_ASSERT(a_count_bound, count_q <= Q_CW'(Q_DEPTH), "queue count above depth")
  `MDSPR_ASSERT(a_pop_nonempty, !(pop_i && empty_o), "queue popped while empty")

endmodule

### rtl/mdspr_back.sv
// back end: video memory access, pixel decode and result register
// depends on mdspr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "masked_dual_screen_pixel_ram_macros.svh"

module mdspr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mdspr_pkg::op_t pop_op_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [15:0]    read_data_o,
  output logic [11:0]    palette_index_o
);
  import mdspr_pkg::*;

  logic [15:0] mem_q [MEM_WORDS];
  logic [15:0] mem_rd_q;
  logic        s1_valid_q;
  kind_e       s1_kind_q;
  logic        out_valid_q;
  logic [15:0] read_data_q;
  logic [11:0] palette_q;
  logic        out_free;
  logic        s1_free;
  logic        s1_move;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || out_free;
  assign pop_o    = !empty_i && s1_free;

  // video memory with bit write enables, registered read
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mem_rd_q <= mem_q[pop_op_i.addr];
      if (pop_op_i.kind == KIND_RAM_WR) begin
        for (int b = 0; b < 16; b++) begin
          if (pop_op_i.bit_en[b]) begin
            mem_q[pop_op_i.addr][b] <= pop_op_i.data[b];
          end
        end
      end
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= pop_o;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage payload and result word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_kind_q <= pop_op_i.kind;
    end
    if (s1_move) begin
      unique case (s1_kind_q)
        KIND_RAM_RD: begin
          read_data_q <= mem_rd_q;
          palette_q   <= '0;
        end
        KIND_CTRL_RD: begin
          read_data_q <= CTRL_READ_VALUE;
          palette_q   <= '0;
        end
        KIND_PIX: begin
          read_data_q <= '0;
          palette_q   <= decode_pixel(mem_rd_q);
        end
        default: begin
          read_data_q <= '0;
          palette_q   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign palette_index_o = palette_q;

  `MDSPR_ASSERT_NEXT(a_s1_hold, s1_valid_q && out_valid_q && out_stall_i, s1_valid_q,
                     "memory stage lost a word while the output stalled")

endmodule

### rtl/masked_dual_screen_pixel_ram.sv
// an accepted input word is registered in the queue, then in the memory read stage, then in the output register
// throughput: one word per cycle while the output does not stall, set by the single port of the video memory
// a two-entry queue lets input acceptance continue while the output stalls
// reset clears ctrl and mask registers and all handshake state
// video memory content is not cleared and is undefined until written
`timescale 1ns / 1ps

module masked_dual_screen_pixel_ram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [17:0] word_address_i,
  input  logic [15:0] write_data_i,
  input  logic [1:0]  byte_lanes_i,
  input  logic [8:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic [11:0] palette_index_o
);
  import mdspr_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  op_t  push_op;
  op_t  pop_op;

  // accept and classify
  mdspr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .word_address_i (word_address_i),
    .write_data_i   (write_data_i),
    .byte_lanes_i   (byte_lanes_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .full_i         (full),
    .push_o         (push),
    .push_op_o      (push_op)
  );

  // decoupling queue
  mdspr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .full_o    (full),
    .empty_o   (empty)
  );

  // memory access and result
  mdspr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .pop_op_i        (pop_op),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .palette_index_o (palette_index_o)
  );

endmodule
